// ----- hw/rtl/b2rd_pkg.sv -----
// b2rd_pkg: shared types, constants and the digit encoding function for the
// binary to radix digits unit. No dependencies.

package b2rd_pkg;

    localparam int unsigned IN_VALUE_W = 64;
    localparam int unsigned RADIX_W    = 6;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned CHUNK_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 8'h41;
    localparam logic [CHAR_W-1:0]  ERR_CHAR   = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_NEXT_DIGIT,
        ST_READ,
        ST_SEND,
        ST_ERR
    } b2rd_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd_init;
        logic rd;
        logic set_err;
    } b2rd_cmd_t;

    typedef struct packed {
        logic in_radix_bad;
        logic last_chunk;
        logic quot_zero;
        logic buf_full;
        logic out_last;
    } b2rd_status_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/binary_to_radix_digits_unit.sv -----
// binary_to_radix_digits_unit: converts an unsigned value into upper-case ASCII
// digits of radix 2..36, most significant first. Each digit comes from chunked long
// division by the radix, one quotient byte per cycle; each item then goes out by a buffer
// read and a send. A bad radix or buffer overflow gives one error item. Reset (aresetn
// low, synchronous) returns the sequencer to idle; the buffer is not cleared.

module binary_to_radix_digits_unit
    import b2rd_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_DIGITS  = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_VALUE_W-1:0] s_value,
    input  logic [RADIX_W-1:0]    s_radix,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHAR_W-1:0]     m_digit_char,
    output logic                  m_last,
    output logic                  m_error
);

    b2rd_cmd_t    cmd;
    b2rd_status_t status;

    b2rd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    b2rd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_value      (s_value),
        .s_radix      (s_radix),
        .cmd          (cmd),
        .status       (status),
        .m_digit_char (m_digit_char),
        .m_last       (m_last),
        .m_error      (m_error)
    );

endmodule

// ----- hw/rtl/b2rd_ctrl.sv -----
// b2rd_ctrl: sequencing state machine for the binary to radix digits unit.
// Depends on b2rd_pkg; drives datapath commands and the channel handshakes.

module b2rd_ctrl
    import b2rd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  b2rd_status_t status,
    output b2rd_cmd_t    cmd
);

    b2rd_state_t state_reg;
    b2rd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.in_radix_bad ? ST_ERR : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (status.last_chunk) begin
                    state_next = ST_NEXT_DIGIT;
                end
            end
            ST_NEXT_DIGIT: begin
                if (status.quot_zero) begin
                    state_next = ST_READ;
                end else if (status.buf_full) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    state_next = status.out_last ? ST_IDLE : ST_READ;
                end
            end
            ST_ERR: begin
                state_next = ST_SEND;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            ST_NEXT_DIGIT: begin
                cmd.rd_init = status.quot_zero;
            end
            ST_READ: begin
                cmd.rd = 1'b1;
            end
            ST_SEND: begin
                m_valid = 1'b1;
            end
            ST_ERR: begin
                cmd.set_err = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/b2rd_dp.sv -----
// b2rd_dp: datapath of the binary to radix digits unit: chunked long division
// by the radix, digit buffer memory and the result register. Depends on b2rd_pkg.

module b2rd_dp
    import b2rd_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_DIGITS  = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [IN_VALUE_W-1:0]  s_value,
    input  logic [RADIX_W-1:0]     s_radix,
    input  b2rd_cmd_t              cmd,
    output b2rd_status_t           status,
    output logic [CHAR_W-1:0]      m_digit_char,
    output logic                   m_last,
    output logic                   m_error
);

    localparam int unsigned STEPS  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int unsigned DIV_W  = STEPS * CHUNK_BITS;
    localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);

    logic [DIV_W-1:0]      val_reg;
    logic [DIV_W-1:0]      val_next;
    logic [RADIX_W-1:0]    rem_reg;
    logic [RADIX_W-1:0]    rem_next;
    logic [RADIX_W-1:0]    radix_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CNT_W-1:0]      dig_cnt_reg;
    logic [ADDR_W-1:0]     rd_ptr_reg;
    logic [CHAR_W-1:0]     rd_data_reg;
    logic                  last_reg;
    logic                  err_reg;
    logic [CHUNK_BITS-1:0] qbits;
    logic                  last_chunk;
    logic [CHAR_W-1:0]     dig_mem [MAX_DIGITS];

    // one quotient byte per cycle, restoring division
    always_comb begin
        logic [RADIX_W:0]   t;
        logic [RADIX_W-1:0] r;
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            t = {r, val_reg[DIV_W-1-i]};
            if (t >= {1'b0, radix_reg}) begin
                r                   = RADIX_W'(t - {1'b0, radix_reg});
                qbits[CHUNK_BITS-1-i] = 1'b1;
            end else begin
                r = t[RADIX_W-1:0];
            end
        end
        rem_next = r;
        val_next = (val_reg << CHUNK_BITS) | DIV_W'(qbits);
    end

    assign last_chunk = (step_reg == STEP_W'(STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            dig_cnt_reg <= '0;
            rd_ptr_reg  <= '0;
            rem_reg     <= '0;
        end else begin
            if (cmd.load) begin
                step_reg    <= '0;
                dig_cnt_reg <= '0;
                rem_reg     <= '0;
            end else if (cmd.div_step) begin
                if (last_chunk) begin
                    step_reg    <= '0;
                    rem_reg     <= '0;
                    dig_cnt_reg <= dig_cnt_reg + CNT_W'(1);
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                    rem_reg  <= rem_next;
                end
            end
            if (cmd.rd_init) begin
                rd_ptr_reg <= ADDR_W'(dig_cnt_reg - CNT_W'(1));
            end else if (cmd.rd) begin
                rd_ptr_reg <= rd_ptr_reg - ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg   <= DIV_W'(s_value[VALUE_WIDTH-1:0]);
            radix_reg <= s_radix;
        end else if (cmd.div_step) begin
            val_reg <= val_next;
        end
        if (cmd.rd) begin
            last_reg <= (rd_ptr_reg == '0);
            err_reg  <= 1'b0;
        end else if (cmd.set_err) begin
            last_reg <= 1'b1;
            err_reg  <= 1'b1;
        end
    end

    // digit buffer
    always_ff @(posedge aclk) begin
        if (cmd.div_step && last_chunk) begin
            dig_mem[dig_cnt_reg[ADDR_W-1:0]] <= digit_ascii(rem_next);
        end
        if (cmd.rd) begin
            rd_data_reg <= dig_mem[rd_ptr_reg];
        end
    end

    assign status.in_radix_bad = (s_radix < RADIX_MIN) || (s_radix > RADIX_MAX);
    assign status.last_chunk   = last_chunk;
    assign status.quot_zero    = (val_reg == '0);
    assign status.buf_full     = (dig_cnt_reg == CNT_W'(MAX_DIGITS));
    assign status.out_last     = last_reg;

    assign m_digit_char = err_reg ? ERR_CHAR : rd_data_reg;
    assign m_last       = last_reg;
    assign m_error      = err_reg;

`ifndef SYNTHESIS
    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < radix_reg))
        else $error("remainder not below radix");

    a_cnt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        dig_cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond buffer depth");

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && last_chunk) |-> (dig_cnt_reg < CNT_W'(MAX_DIGITS)))
        else $error("digit written into full buffer");

    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.set_err) |-> (err_reg && last_reg))
        else $error("error item not marked last");
`endif

endmodule

// ----- dv/tb_binary_to_radix_digits_unit.sv -----
// tb_binary_to_radix_digits_unit: self-checking testbench for binary_to_radix_digits_unit.
// Drives values and radices over a valid/ready channel and checks every digit item against
// a digit predictor in a scoreboard class. Needs b2rd_pkg and the unit's RTL.

module tb_binary_to_radix_digits_unit;
    import b2rd_pkg::*;

    localparam int unsigned VALUE_W        = 64;
    localparam int unsigned DIGIT_CAP      = 64;
    localparam int unsigned LO_RADIX       = 2;
    localparam int unsigned HI_RADIX       = 36;
    localparam int unsigned DEC_BASE       = 10;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h41;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned ITEMS_PER_PHASE = 62;
    localparam int unsigned SETTLE_CYCLES  = 800;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_VALUE_W-1:0] s_value;
    logic [RADIX_W-1:0]    s_radix;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHAR_W-1:0]     m_digit_char;
    logic                  m_last;
    logic                  m_error;

    int unsigned idle_pct;
    int unsigned stall_pct;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              err;
    } digit_item_t;

    class digit_scoreboard;
        digit_item_t pending_digits[$];
        int unsigned items_in;
        int unsigned digits_seen;
        int unsigned error_items;
        int unsigned mismatches;

        function void push_error_item();
            digit_item_t e;
            e.ch   = CH_NONE;
            e.last = 1'b1;
            e.err  = 1'b1;
            pending_digits.push_back(e);
        endfunction

        function void note_input(logic [IN_VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
            logic [63:0]       mask;
            logic [63:0]       rest;
            logic [63:0]       base;
            logic [63:0]       rem;
            logic [CHAR_W-1:0] held[$];
            digit_item_t       e;
            int                k;
            items_in++;
            mask = '1;
            if (VALUE_W < 64) begin
                mask = mask >> (64 - VALUE_W);
            end
            rest = value & mask;
            base = 64'(radix);
            if (base < LO_RADIX || base > HI_RADIX) begin
                push_error_item();
                return;
            end
            do begin
                if (held.size() >= DIGIT_CAP) begin
                    push_error_item();
                    return;
                end
                rem = rest % base;
                held.push_back(rem < DEC_BASE ? CH_ZERO + CHAR_W'(rem)
                                              : CH_ALPHA + CHAR_W'(rem - DEC_BASE));
                rest = rest / base;
            end while (rest != 0);
            for (k = held.size() - 1; k >= 0; k--) begin
                e.ch   = held[k];
                e.last = (k == 0);
                e.err  = 1'b0;
                pending_digits.push_back(e);
            end
        endfunction

        function void check_result(logic [CHAR_W-1:0] ch, logic last, logic err);
            digit_item_t e;
            digits_seen++;
            if (pending_digits.size() == 0) begin
                $error("unexpected item: digit_char %h last %b error %b", ch, last, err);
                mismatches++;
                return;
            end
            e = pending_digits.pop_front();
            if (e.err) begin
                error_items++;
            end
            if (ch !== e.ch) begin
                $error("digit_char mismatch: expected %h, got %h", e.ch, ch);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("last mismatch: expected %b, got %b", e.last, last);
                mismatches++;
            end
            if (err !== e.err) begin
                $error("error mismatch: expected %b, got %b", e.err, err);
                mismatches++;
            end
        endfunction
    endclass

    digit_scoreboard sb = new;

    binary_to_radix_digits_unit #(
        .VALUE_WIDTH(VALUE_W),
        .MAX_DIGITS (DIGIT_CAP)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_radix     (s_radix),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_digit_char(m_digit_char),
        .m_last      (m_last),
        .m_error     (m_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_digit_char, m_last, m_error);
        end
    end

    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic [IN_VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_value = value;
        s_radix = radix;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            if (s_ready) begin
                taken = 1'b1;
                sb.note_input(value, radix);
            end
        end
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (sb.pending_digits.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    function automatic logic [IN_VALUE_W-1:0] pick_value();
        logic [IN_VALUE_W-1:0] v;
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: v = {$urandom, $urandom} >> $urandom_range(63);
            2: v = IN_VALUE_W'($urandom_range(1000));
            default: v = (64'd1 << $urandom_range(63)) - IN_VALUE_W'($urandom_range(1));
        endcase
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        logic [RADIX_W-1:0] r;
        if ($urandom_range(9) == 0) begin
            r = ($urandom_range(1) == 0) ? RADIX_W'($urandom_range(1))
                                          : RADIX_W'($urandom_range(63, 37));
        end else begin
            r = RADIX_W'($urandom_range(HI_RADIX, LO_RADIX));
        end
        return r;
    endfunction

    initial begin
        int unsigned phase;
        int unsigned n;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_value   = '0;
        s_radix   = '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // extremes, digit boundaries and bad radices
        send_item(64'd0, 6'd10);
        send_item(64'd0, 6'd2);
        send_item(64'd0, 6'd36);
        send_item('1, 6'd2);
        send_item('1, 6'd3);
        send_item('1, 6'd16);
        send_item('1, 6'd36);
        send_item(64'h8000_0000_0000_0000, 6'd2);
        send_item(64'd1, 6'd2);
        send_item(64'd9, 6'd10);
        send_item(64'd10, 6'd10);
        send_item(64'd10, 6'd11);
        send_item(64'd35, 6'd36);
        send_item(64'd36, 6'd36);
        send_item(64'd12345678, 6'd10);
        send_item(64'h5555_5555_5555_5555, 6'd35);
        send_item(64'hDEAD_BEEF_0123_4567, 6'd0);
        send_item(64'd0, 6'd0);
        send_item('1, 6'd1);
        send_item(64'd7, 6'd37);
        send_item('1, 6'd63);
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 70; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 70; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(pick_value(), pick_radix());
                if ($urandom_range(19) == 0) begin
                    drain_results();
                end
            end
            drain_results();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.pending_digits.size() != 0) begin
            $error("%0d expected items never arrived", sb.pending_digits.size());
            sb.mismatches++;
        end
        $display("converted %0d input items into %0d result items (%0d of them error items)",
                 sb.items_in, sb.digits_seen, sb.error_items);
        $display("radices 0 to 63 across four idle and stall settings, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/b2rd_pkg.sv
hw/rtl/b2rd_ctrl.sv
hw/rtl/b2rd_dp.sv
hw/rtl/binary_to_radix_digits_unit.sv
dv/tb_binary_to_radix_digits_unit.sv
